@@ design/assert_macros.svh @@
// Assertion macros for the RTL file that carries concurrent checks.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/hbb_pkg.sv @@
// Shared constants and types of the gray horizontal box blur.
// No dependencies; used by every other file of the block but assert_macros.svh.
package hbb_pkg;

    localparam int PORT_BITS   = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int RADIUS      = 10;

    localparam int WIN_LEN  = 2 * RADIUS + 1;
    localparam int CNT_BITS = $clog2(WIN_LEN + 1);
    localparam int D_BITS   = $clog2(RADIUS + 1);
    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WIN_LEN);

    // Reciprocal division of the window sum: exact for sum < 2**SUM_BITS, count <= WIN_LEN.
    localparam int RECIP_SHIFT = SUM_BITS + CNT_BITS;
    localparam int RECIP_BITS  = RECIP_SHIFT + 1;
    localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;

    // Gray conversion: floor(x / 3) as (x * GRAY_RECIP) >> GRAY_SHIFT.
    localparam int GRAY_SUM_BITS  = SAMPLE_BITS + 2;
    localparam int GRAY_SHIFT     = SAMPLE_BITS + 3;
    localparam int GRAY_RECIP_INT = ((2 ** GRAY_SHIFT) + 2) / 3;
    localparam logic [GRAY_SHIFT-1:0] GRAY_RECIP = GRAY_SHIFT'(GRAY_RECIP_INT);
    localparam int GRAY_PROD_BITS = GRAY_SUM_BITS + GRAY_SHIFT;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef logic [SAMPLE_BITS-1:0] t_gray;

    // One pixel as the back end sees it.
    typedef struct packed {
        t_gray gray;
        logic  row_end;
    } t_cmd;

    // One result waiting for its division.
    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic [CNT_BITS-1:0] cnt;
        logic                row_last;
    } t_div_req;

    typedef struct packed {
        logic flushing;
        logic row_open;
    } t_back_stat;

endpackage

@@ design/hbb_if.sv @@
// Stream interfaces of the gray horizontal box blur: pixel input and result output.
// Depends on hbb_pkg for the port width.
interface hbb_pix_if;
    logic                           valid;
    logic                           ready;
    logic [hbb_pkg::PORT_BITS-1:0]  red;
    logic [hbb_pkg::PORT_BITS-1:0]  green;
    logic [hbb_pkg::PORT_BITS-1:0]  blue;
    logic                           row_end;

    modport source (output valid, red, green, blue, row_end, input ready);
    modport sink   (input valid, red, green, blue, row_end, output ready);
endinterface

interface hbb_res_if;
    logic                           valid;
    logic                           ready;
    logic [hbb_pkg::PORT_BITS-1:0]  blurred_gray;
    logic                           row_last;

    modport source (output valid, blurred_gray, row_last, input ready);
    modport sink   (input valid, blurred_gray, row_last, output ready);
endinterface

@@ design/hbb_front.sv @@
// Front end: accepts RGB beats, converts them to gray and registers one command.
// Depends on hbb_pkg and hbb_pix_if.
module hbb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    hbb_pix_if.sink         i_pix,
    output logic            o_cmd_valid,
    input  logic            i_cmd_ready,
    output hbb_pkg::t_cmd   o_cmd
);

    logic                                   r_valid;
    hbb_pkg::t_cmd                          r_cmd;
    logic [hbb_pkg::GRAY_SUM_BITS-1:0]      w_rgb_sum;
    logic [hbb_pkg::GRAY_PROD_BITS-1:0]     w_prod;
    logic                                   w_take;

    assign i_pix.ready = !r_valid || i_cmd_ready;
    assign w_take      = i_pix.valid && i_pix.ready;

    always_comb begin
        w_rgb_sum = hbb_pkg::GRAY_SUM_BITS'(i_pix.red[hbb_pkg::SAMPLE_BITS-1:0])
                  + hbb_pkg::GRAY_SUM_BITS'(i_pix.green[hbb_pkg::SAMPLE_BITS-1:0])
                  + hbb_pkg::GRAY_SUM_BITS'(i_pix.blue[hbb_pkg::SAMPLE_BITS-1:0]);
        w_prod = hbb_pkg::GRAY_PROD_BITS'(w_rgb_sum)
               * hbb_pkg::GRAY_PROD_BITS'(hbb_pkg::GRAY_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd.gray    <= w_prod[hbb_pkg::GRAY_SHIFT +: hbb_pkg::SAMPLE_BITS];
            r_cmd.row_end <= i_pix.row_end;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

@@ design/hbb_fifo.sv @@
// Short command queue between the front end and the back end.
// Depends on hbb_pkg.
module hbb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  hbb_pkg::t_cmd   i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output hbb_pkg::t_cmd   o_cmd
);

    hbb_pkg::t_cmd                  r_mem [hbb_pkg::FIFO_DEPTH];
    logic [hbb_pkg::FIFO_AW-1:0]    r_wr_ptr;
    logic [hbb_pkg::FIFO_AW-1:0]    r_rd_ptr;
    logic [hbb_pkg::FIFO_AW:0]      r_count;
    logic                           w_push;
    logic                           w_pop;

    assign o_ready = (r_count != (hbb_pkg::FIFO_AW + 1)'(hbb_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

@@ design/hbb_back.sv @@
// Back end: holds the gray window and its running sum, and issues one division
// request per result, sequencing the row-end flush. Depends on hbb_pkg.
module hbb_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    output logic                    o_cmd_ready,
    input  hbb_pkg::t_cmd           i_cmd,
    output logic                    o_req_valid,
    input  logic                    i_req_ready,
    output hbb_pkg::t_div_req       o_req,
    output hbb_pkg::t_back_stat     o_stat
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FLUSH = 2'b10
    } t_state;

    t_state                         r_state;
    hbb_pkg::t_gray                 r_win [hbb_pkg::WIN_LEN];
    logic [hbb_pkg::SUM_BITS-1:0]   r_sum;
    logic [hbb_pkg::CNT_BITS-1:0]   r_avail;
    logic [hbb_pkg::D_BITS-1:0]     r_d;

    logic [hbb_pkg::SUM_BITS-1:0]   w_add_sum;
    logic [hbb_pkg::CNT_BITS-1:0]   w_add_avail;
    logic [hbb_pkg::D_BITS-1:0]     w_d0;
    logic [hbb_pkg::SUM_BITS-1:0]   w_drop_sum;
    logic [hbb_pkg::D_BITS-1:0]     w_d_next;
    logic [hbb_pkg::CNT_BITS-1:0]   w_reach;
    logic [hbb_pkg::CNT_BITS-1:0]   w_flush_cnt;
    logic                           w_pop;
    logic                           w_step;

    always_comb begin
        w_add_sum   = r_sum + hbb_pkg::SUM_BITS'(i_cmd.gray)
                    - hbb_pkg::SUM_BITS'(r_win[hbb_pkg::WIN_LEN-1]);
        w_add_avail = (r_avail == hbb_pkg::CNT_BITS'(hbb_pkg::WIN_LEN)) ? r_avail
                    : r_avail + 1'b1;
        w_d0        = (w_add_avail > hbb_pkg::CNT_BITS'(hbb_pkg::RADIUS))
                    ? hbb_pkg::D_BITS'(hbb_pkg::RADIUS)
                    : hbb_pkg::D_BITS'(w_add_avail - 1'b1);
        w_drop_sum  = r_sum - hbb_pkg::SUM_BITS'(r_win[hbb_pkg::WIN_LEN-1]);
        w_d_next    = r_d - 1'b1;
        w_reach     = hbb_pkg::CNT_BITS'(w_d_next) + hbb_pkg::CNT_BITS'(hbb_pkg::RADIUS + 1);
        w_flush_cnt = (w_reach < r_avail) ? w_reach : r_avail;
    end

    assign o_cmd_ready = (r_state == ST_IDLE) && i_req_ready;
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_step      = (r_state == ST_FLUSH) && i_req_ready;

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                o_req_valid    = i_cmd_valid && (i_cmd.row_end
                               || (w_add_avail >= hbb_pkg::CNT_BITS'(hbb_pkg::RADIUS + 1)));
                o_req.sum      = w_add_sum;
                o_req.cnt      = w_add_avail;
                o_req.row_last = i_cmd.row_end && (w_add_avail == hbb_pkg::CNT_BITS'(1));
            end
            ST_FLUSH: begin
                o_req_valid    = 1'b1;
                o_req.sum      = w_drop_sum;
                o_req.cnt      = w_flush_cnt;
                o_req.row_last = (w_d_next == '0);
            end
            default: begin
                o_req_valid    = 1'b0;
                o_req.sum      = w_add_sum;
                o_req.cnt      = w_add_avail;
                o_req.row_last = 1'b0;
            end
        endcase
    end

    assign o_stat.flushing = (r_state == ST_FLUSH);
    assign o_stat.row_open = (r_avail != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_avail <= '0;
            r_d     <= '0;
            for (int k = 0; k < hbb_pkg::WIN_LEN; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_pop && i_cmd.row_end && (w_d0 == '0)) begin
            // Single-pixel row: its only result goes out now, the row restarts.
            r_sum   <= '0;
            r_avail <= '0;
            for (int k = 0; k < hbb_pkg::WIN_LEN; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_pop) begin
            r_win[0] <= i_cmd.gray;
            for (int k = 1; k < hbb_pkg::WIN_LEN; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_sum   <= w_add_sum;
            r_avail <= w_add_avail;
            if (i_cmd.row_end) begin
                r_d     <= w_d0;
                r_state <= ST_FLUSH;
            end
        end else if (w_step && (w_d_next == '0)) begin
            r_state <= ST_IDLE;
            r_sum   <= '0;
            r_avail <= '0;
            for (int k = 0; k < hbb_pkg::WIN_LEN; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_step) begin
            // The oldest entry leaves the window; zeros fill from the new end.
            r_win[0] <= '0;
            for (int k = 1; k < hbb_pkg::WIN_LEN; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_sum <= w_drop_sum;
            r_d   <= w_d_next;
        end
    end

endmodule

@@ design/hbb_div.sv @@
// Two-stage divider of window sums by pixel counts through a reciprocal table,
// with the output register of the result stream. Depends on hbb_pkg, hbb_res_if.
module hbb_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    output logic                    o_req_ready,
    input  hbb_pkg::t_div_req       i_req,
    hbb_res_if.source               o_res
);

    localparam int TAB_LEN = 2 ** hbb_pkg::CNT_BITS;

    logic [hbb_pkg::RECIP_BITS-1:0] w_recip [TAB_LEN];

    logic                           r1_valid;
    logic [hbb_pkg::SUM_BITS-1:0]   r1_sum;
    logic [hbb_pkg::RECIP_BITS-1:0] r1_recip;
    logic                           r1_last;
    logic                           r2_valid;
    logic [hbb_pkg::PROD_BITS-1:0]  r2_prod;
    logic                           r2_last;
    logic                           w_adv;

    for (genvar n = 0; n < TAB_LEN; n++) begin : g_recip
        if ((n == 0) || (n > hbb_pkg::WIN_LEN)) begin : g_unused
            assign w_recip[n] = '0;
        end else begin : g_used
            localparam int RECIP_INT = ((2 ** hbb_pkg::RECIP_SHIFT) + n - 1) / n;
            assign w_recip[n] = hbb_pkg::RECIP_BITS'(RECIP_INT);
        end
    end

    assign w_adv       = !r2_valid || o_res.ready;
    assign o_req_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid <= i_req_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_sum   <= i_req.sum;
            r1_recip <= w_recip[i_req.cnt];
            r1_last  <= i_req.row_last;
            r2_prod  <= hbb_pkg::PROD_BITS'(r1_sum) * hbb_pkg::PROD_BITS'(r1_recip);
            r2_last  <= r1_last;
        end
    end

    assign o_res.valid        = r2_valid;
    assign o_res.blurred_gray = hbb_pkg::PORT_BITS'(
                                    r2_prod[hbb_pkg::RECIP_SHIFT +: hbb_pkg::SAMPLE_BITS]);
    assign o_res.row_last     = r2_last;

endmodule

@@ design/gray_horizontal_box_blur.sv @@
// Gray horizontal box blur. RGB pixels come in raster order, one per beat, with
// row_end on the last pixel of each row. Each pixel becomes gray as the floor of
// (red + green + blue) / 3, and each gray value leaves as the floor mean of itself
// and up to 10 gray neighbors on each side in the same row; near a row end the
// window is cut short and the divisor is the number of pixels in it. A result
// appears once its tenth right neighbor has come in, so results lag the input
// by 10 pixels; the row_end pixel releases every outstanding result of its row,
// the final one marked with row_last. Inside the row the block takes one pixel
// per cycle unless the output stalls. A row_end pixel occupies the back end
// while it releases its min(row length, 11) results, one at a time; a 4-beat
// command queue lets the input keep running into that time, and a longer backlog
// stalls the input. The path from input beat to result beat is registered at the
// gray conversion, the queue, the window update together with the reciprocal
// lookup, and the multiply into the output register.
// Depends on hbb_pkg, hbb_if, hbb_front, hbb_fifo, hbb_back, hbb_div and
// assert_macros.svh.
`include "assert_macros.svh"

module gray_horizontal_box_blur (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbb_pix_if.sink     i_pix,
    hbb_res_if.source   o_res
);

    // Front end to queue.
    logic                   w_fcmd_valid;
    logic                   w_fcmd_ready;
    hbb_pkg::t_cmd          w_fcmd;

    // Queue to back end.
    logic                   w_cmd_valid;
    logic                   w_cmd_ready;
    hbb_pkg::t_cmd          w_cmd;

    // Back end to divider.
    logic                   w_req_valid;
    logic                   w_req_ready;
    hbb_pkg::t_div_req      w_req;
    hbb_pkg::t_back_stat    w_back_stat;

    // The front end converts each accepted pixel to gray in a single stage.
    hbb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (i_pix),
        .o_cmd_valid (w_fcmd_valid),
        .i_cmd_ready (w_fcmd_ready),
        .o_cmd       (w_fcmd)
    );

    // The queue absorbs pixels that arrive while a row end is being flushed.
    hbb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fcmd_valid),
        .o_ready (w_fcmd_ready),
        .i_cmd   (w_fcmd),
        .o_valid (w_cmd_valid),
        .i_ready (w_cmd_ready),
        .o_cmd   (w_cmd)
    );

    // The back end keeps the 21-entry window and its running sum. A plain pixel
    // yields at most one request; a row-end pixel starts a flush that drops the
    // oldest entry from the sum on each step.
    hbb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .o_req_valid (w_req_valid),
        .i_req_ready (w_req_ready),
        .o_req       (w_req),
        .o_stat      (w_back_stat)
    );

    // The divider scales the sum by the reciprocal of the pixel count; its
    // last stage is the output register of the result stream.
    hbb_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .o_req_ready (w_req_ready),
        .i_req       (w_req),
        .o_res       (o_res)
    );

    // Every division request has a pixel count between one and the window length.
    `ASSERT_IMP(a_req_cnt_range, i_clk, i_rst_n, w_req_valid, (w_req.cnt != '0) && (w_req.cnt <= hbb_pkg::CNT_BITS'(hbb_pkg::WIN_LEN)), "division request with a bad pixel count")
    // Handing over the final result of a row ends the flush.
    `ASSERT_NXT(a_flush_ends, i_clk, i_rst_n, w_req_valid && w_req_ready && w_req.row_last, !w_back_stat.flushing && !w_back_stat.row_open, "flush still running after the final result")
    // No new pixel enters the window while a flush is under way.
    `ASSERT_IMP(a_no_pop_in_flush, i_clk, i_rst_n, w_back_stat.flushing, !w_cmd_ready, "queue popped during a flush")

endmodule
